// ===== hdl/vt4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_pkg
// types and constants shared by the vertex transform pipeline
// ----------------------------------------------------------------------------
package vt4_pkg;

  localparam int PROD_W    = 64;
  localparam int SUM_W     = 66;
  localparam int DIV_STEPS = 32;
  localparam int NUM_REGS  = 8;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic               last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic               w_zero;
    logic               saturated;
    logic               last_out;
  } out_word_t;

  typedef struct packed {
    logic             bypass;
    logic             wzero;
    logic             last;
    logic [2:0]       nneg;
    logic [2:0]       nzero;
    logic [2:0]       qneg;
    logic [2:0]       ovf;
    logic [2:0]       bsat;
    logic [2:0][31:0] bx;
  } side_t;

endpackage

// ===== hdl/vt4_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module vt4_div
  import vt4_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [SUM_W-1:0]   num_i,
  input  logic [SUM_W-1:0]   den_i,
  output logic [31:0]        q_o
);

  logic [SUM_W-1:0] rem_r [DIV_STEPS];
  logic [SUM_W-1:0] den_r [DIV_STEPS];
  logic [31:0]      qd_r  [DIV_STEPS];

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [SUM_W-1:0] rem_in;
      logic [SUM_W-1:0] den_in;
      logic [31:0]      qd_in;
      logic [SUM_W:0]   trial;
      logic             ge;
      logic [SUM_W-1:0] rem_nxt;
      logic [31:0]      qd_nxt;

      if (k == 0) begin : g_first
        assign rem_in = {16'h0, num_i[SUM_W-1:16]};
        assign qd_in  = {num_i[15:0], 16'h0};
        assign den_in = den_i;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign qd_in  = qd_r[k-1];
        assign den_in = den_r[k-1];
      end

      always_comb begin
        trial   = {rem_in, qd_in[31]};
        ge      = (trial >= {1'b0, den_in});
        rem_nxt = ge ? SUM_W'(trial - {1'b0, den_in}) : trial[SUM_W-1:0];
        qd_nxt  = {qd_in[30:0], ge};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
          qd_r[k]  <= qd_nxt;
        end
      end
    end
  endgenerate

  assign q_o = qd_r[DIV_STEPS-1];

endmodule

// ===== hdl/vertex_transform_4x4.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// homogeneous 4x4 vertex transform with perspective divide, Q16.16
// ----------------------------------------------------------------------------
// One vertex word is taken per cycle, and its result passes through one
// multiply stage, one sum stage, two prepare stages, a 32-stage divider
// (one quotient bit per stage, three dividers side by side) and the output
// register. The divider stages set the latency; throughput is one word per
// clock. The whole pipe holds while the output word is stalled. The matrix
// is written over the APB port at byte address 8*i and must only change while
// the pipe is empty.
module vertex_transform_4x4
  import vt4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] mreg_r [NUM_REGS];
  logic [31:0]       mel [4][4];
  logic              en;
  logic              bypass;

  // matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mreg_r[0] <= {32'h0, ONE_Q16};
      mreg_r[1] <= '0;
      mreg_r[2] <= {ONE_Q16, 32'h0};
      mreg_r[3] <= '0;
      mreg_r[4] <= '0;
      mreg_r[5] <= {32'h0, ONE_Q16};
      mreg_r[6] <= '0;
      mreg_r[7] <= {ONE_Q16, 32'h0};
    end else if (psel && penable && pwrite) begin
      mreg_r[paddr[5:3]] <= pwdata;
    end
  end

  assign prdata = mreg_r[paddr[5:3]];
  assign pready = 1'b1;

  genvar r, c;
  generate
    for (c = 0; c < 4; c++) begin : g_col
      for (r = 0; r < 4; r++) begin : g_row
        assign mel[r][c] = mreg_r[2*c + r/2][(r%2)*32 +: 32];
      end
    end
  endgenerate

  assign bypass = (mel[3][0] == '0) && (mel[3][1] == '0) && (mel[3][2] == '0) &&
                  (mel[3][3] == ONE_Q16);

  // pipe control
  logic      out_valid_r;
  out_word_t out_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 1: products
  logic               v1_r, last1_r;
  logic signed [PROD_W-1:0] prod_r [4][3];
  logic signed [31:0] pin [3];

  assign pin[0] = in_data.x_in;
  assign pin[1] = in_data.y_in;
  assign pin[2] = in_data.z_in;

  always_ff @(posedge clk) begin
    if (en) begin
      last1_r <= in_data.last_in;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3; j++)
          prod_r[i][j] <= $signed(mel[i][j]) * pin[j];
    end
  end

  // stage 2: row sums
  logic                    v2_r, last2_r;
  logic [SUM_W-1:0]        sum_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      last2_r <= last1_r;
      for (int i = 0; i < 4; i++)
        sum_r[i] <= {{2{prod_r[i][0][PROD_W-1]}}, prod_r[i][0]} +
                    {{2{prod_r[i][1][PROD_W-1]}}, prod_r[i][1]} +
                    {{2{prod_r[i][2][PROD_W-1]}}, prod_r[i][2]} +
                    {{18{mel[i][3][31]}}, mel[i][3], 16'h0};
    end
  end

  // stage 3: magnitudes and bypass results
  logic             v3_r;
  side_t            side3_r, side3_nxt;
  logic [SUM_W-1:0] absn3_r [3];
  logic [SUM_W-1:0] absn3_nxt [3];
  logic [SUM_W-1:0] absw3_r;

  always_comb begin
    side3_nxt        = '0;
    side3_nxt.bypass = bypass;
    side3_nxt.last   = last2_r;
    side3_nxt.wzero  = (sum_r[3] == '0);
    for (int i = 0; i < 3; i++) begin
      side3_nxt.nneg[i]  = sum_r[i][SUM_W-1];
      side3_nxt.nzero[i] = (sum_r[i] == '0);
      side3_nxt.qneg[i]  = sum_r[i][SUM_W-1] ^ sum_r[3][SUM_W-1];
      absn3_nxt[i] = sum_r[i][SUM_W-1] ? SUM_W'(-sum_r[i]) : sum_r[i];
      side3_nxt.bsat[i] = !((&sum_r[i][SUM_W-1:47]) || !(|sum_r[i][SUM_W-1:47]));
      if (side3_nxt.bsat[i])
        side3_nxt.bx[i] = sum_r[i][SUM_W-1] ? NEG_MAX : POS_MAX;
      else
        side3_nxt.bx[i] = sum_r[i][47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side3_nxt;
      absw3_r <= sum_r[3][SUM_W-1] ? SUM_W'(-sum_r[3]) : sum_r[3];
      for (int i = 0; i < 3; i++) absn3_r[i] <= absn3_nxt[i];
    end
  end

  // stage 4: quotient overflow, divider operands
  logic [SUM_W-1:0] absn4_r [3];
  logic [SUM_W-1:0] absw4_r;
  side_t            side_r [DIV_STEPS+1];
  logic             sv_r   [DIV_STEPS+1];
  side_t            side4_nxt;

  always_comb begin
    side4_nxt = side3_r;
    for (int i = 0; i < 3; i++)
      side4_nxt.ovf[i] = ({16'h0, absn3_r[i]} >= {absw3_r, 16'h0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side4_nxt;
      absw4_r   <= absw3_r;
      for (int i = 0; i < 3; i++) absn4_r[i] <= absn3_r[i];
      for (int i = 0; i < DIV_STEPS; i++) side_r[i+1] <= side_r[i];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) sv_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      sv_r[0] <= v3_r;
      for (int i = 0; i < DIV_STEPS; i++) sv_r[i+1] <= sv_r[i];
      out_valid_r <= sv_r[DIV_STEPS];
    end
  end

  // dividers
  logic [31:0] q [3];

  genvar d;
  generate
    for (d = 0; d < 3; d++) begin : g_div
      vt4_div u_div (
        .clk   (clk),
        .en    (en),
        .num_i (absn4_r[d]),
        .den_i (absw4_r),
        .q_o   (q[d])
      );
    end
  endgenerate

  // output stage
  out_word_t out_nxt;
  side_t     sf;
  logic [31:0] res [3];
  logic [2:0]  csat;

  always_comb begin
    sf = side_r[DIV_STEPS];
    for (int i = 0; i < 3; i++) begin
      csat[i] = 1'b0;
      if (sf.bypass) begin
        res[i]  = sf.bx[i];
        csat[i] = sf.bsat[i];
      end else if (sf.nzero[i]) begin
        res[i] = '0;
      end else if (sf.wzero) begin
        res[i]  = sf.nneg[i] ? NEG_MAX : POS_MAX;
        csat[i] = 1'b1;
      end else if (sf.ovf[i] || (sf.qneg[i] ? (q[i] > NEG_MAX) : (q[i] > POS_MAX))) begin
        res[i]  = sf.qneg[i] ? NEG_MAX : POS_MAX;
        csat[i] = 1'b1;
      end else begin
        res[i] = sf.qneg[i] ? 32'(-q[i]) : q[i];
      end
    end
    out_nxt.x_out     = res[0];
    out_nxt.y_out     = res[1];
    out_nxt.z_out     = res[2];
    out_nxt.w_zero    = !sf.bypass && sf.wzero;
    out_nxt.saturated = |csat;
    out_nxt.last_out  = sf.last;
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

endmodule

// ===== hdl/vt4_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt4_check
// port-level checks for the vertex transform, bound to the top level
// ----------------------------------------------------------------------------
module vt4_check
  import vt4_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input out_word_t         out_data
);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled word changed");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held without output back-pressure");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("word out of reset");

  a_wzero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.w_zero && out_data.x_out != 0 |-> out_data.saturated)
    else $error("zero w without saturation");

endmodule

bind vertex_transform_4x4 vt4_check u_vt4_check (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 4x4 vertex transform
// ----------------------------------------------------------------------------
// Uses the reset identity, then loads bypass, perspective, extreme and random
// matrices over the APB port. The first three get directed vertices, the rest
// random ones; the random matrices run under several sender and receiver
// idle patterns. A local Q16.16 transform predicts each result, checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import vt4_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic signed [31:0] mat [16];
  in_word_t           vertex_q [$];
  out_word_t          result_q [$];
  int                 send_idle_pct;
  int                 stall_pct;
  int                 errors = 0;

  vertex_transform_4x4 dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] clip32(input logic signed [127:0] v, ref bit sat);
    if (v > 128'sh7FFF_FFFF) begin
      sat = 1'b1;
      return POS_MAX;
    end
    if (v < -128'sh8000_0000) begin
      sat = 1'b1;
      return NEG_MAX;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] q16_divide(input logic signed [127:0] n,
                                             input logic signed [127:0] w, ref bit sat);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    bit           neg;
    if (n == 0) return '0;
    if (w == 0) begin
      sat = 1'b1;
      return n < 0 ? NEG_MAX : POS_MAX;
    end
    neg = (n < 0) != (w < 0);
    num = (n < 0 ? -n : n) << 16;
    den = w < 0 ? -w : w;
    q = num / den;
    if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
      sat = 1'b1;
      return neg ? NEG_MAX : POS_MAX;
    end
    q = neg ? -q : q;
    return q[31:0];
  endfunction

  function automatic out_word_t transform_vertex(input in_word_t v);
    logic signed [127:0] s [4];
    logic signed [127:0] a, b, c, d, px, py, pz;
    out_word_t           r;
    bit                  sat;
    px = v.x_in;
    py = v.y_in;
    pz = v.z_in;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a = mat[i];
      b = mat[4+i];
      c = mat[8+i];
      d = mat[12+i];
      s[i] = a * px + b * py + c * pz + (d <<< 16);
    end
    r = '0;
    if (mat[3] == 0 && mat[7] == 0 && mat[11] == 0 && mat[15] == ONE_Q16) begin
      r.x_out = clip32(s[0] >>> 16, sat);
      r.y_out = clip32(s[1] >>> 16, sat);
      r.z_out = clip32(s[2] >>> 16, sat);
    end else begin
      r.w_zero = (s[3] == 0);
      r.x_out = q16_divide(s[0], s[3], sat);
      r.y_out = q16_divide(s[1], s[3], sat);
      r.z_out = q16_divide(s[2], s[3], sat);
    end
    r.saturated = sat;
    r.last_out = v.last_in;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h, expected %h", what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) result_q.push_back(transform_vertex(in_data));
      if (!in_valid || !in_stall) begin
        if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= vertex_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected word", out_data.x_out, 32'h0);
      end else begin
        want = result_q.pop_front();
        if (out_data.x_out !== want.x_out) report_mismatch("x", out_data.x_out, want.x_out);
        if (out_data.y_out !== want.y_out) report_mismatch("y", out_data.y_out, want.y_out);
        if (out_data.z_out !== want.z_out) report_mismatch("z", out_data.z_out, want.z_out);
        if (out_data.w_zero !== want.w_zero)
          report_mismatch("w_zero", out_data.w_zero, want.w_zero);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", out_data.saturated, want.saturated);
        if (out_data.last_out !== want.last_out)
          report_mismatch("last", out_data.last_out, want.last_out);
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (vertex_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_matrix(input logic signed [31:0] m [16]);
    int base;
    for (int i = 0; i < NUM_REGS; i++) begin
      base = (i >> 1) * 4 + (i & 1) * 2;
      @(posedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(i * 8);
      pwdata <= {m[base+1], m[base]};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
    end
    mat = m;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($urandom_range(32'h40000)) * ($urandom_range(1) ? 1 : -1);
      default: return 32'($urandom_range(32'h2000000)) - 32'h1000000;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(4))
      0: return $urandom();
      1: return '0;
      2: return ONE_Q16;
      default: return 32'($urandom_range(32'h40000)) - 32'h20000;
    endcase
  endfunction

  task automatic push_random(input int count);
    in_word_t v;
    repeat (count) begin
      v.x_in = rand_coord();
      v.y_in = rand_coord();
      v.z_in = rand_coord();
      v.last_in = 1'($urandom_range(1));
      vertex_q.push_back(v);
    end
  endtask

  task automatic push_vertex(input logic [31:0] x, y, z, input logic last);
    in_word_t v;
    v.x_in = x;
    v.y_in = y;
    v.z_in = z;
    v.last_in = last;
    vertex_q.push_back(v);
  endtask

  initial begin
    logic signed [31:0] m [16];
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    foreach (mat[i]) mat[i] = (i % 5 == 0) ? ONE_Q16 : '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset: bypass path with extremes
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
    push_vertex(32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 1'b1);
    push_vertex(32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0);
    wait_drained();

    // bypass with scale and translation that saturate
    foreach (m[i]) m[i] = '0;
    m[0] = 32'h7FFF_FFFF; m[5] = 32'h8000_0000; m[10] = 32'h0002_0000;
    m[12] = 32'h7FFF_FFFF; m[13] = 32'h8000_0000; m[15] = ONE_Q16;
    load_matrix(m);
    push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    push_vertex(32'h0, 32'h0, 32'hC000_0000, 1'b0);
    push_vertex(32'hFFFF_FFFF, 32'h1, 32'h1, 1'b0);
    wait_drained();

    // perspective: w = z, zero w with positive, negative and zero numerators
    foreach (m[i]) m[i] = '0;
    m[0] = ONE_Q16; m[5] = ONE_Q16; m[10] = ONE_Q16; m[11] = ONE_Q16;
    load_matrix(m);
    push_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0);
    push_vertex(32'h0, 32'h0, 32'h0, 1'b1);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
    push_vertex(32'h0003_0000, 32'hFFFD_0000, 32'h0002_0000, 1'b0);
    push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_vertex(32'h0005_0000, 32'h0, 32'hFFFE_0000, 1'b0);
    wait_drained();

    // all entries at minus one LSB, then at alternating extremes
    foreach (m[i]) m[i] = 32'hFFFF_FFFF;
    load_matrix(m);
    push_random(6);
    wait_drained();
    foreach (m[i]) m[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
    load_matrix(m);
    push_random(6);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      foreach (m[i]) m[i] = rand_entry();
      if (phase % 4 == 1) begin
        m[3] = '0; m[7] = '0; m[11] = '0; m[15] = ONE_Q16;
      end
      load_matrix(m);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      push_random(110);
      if (phase == 3) wait_drained();
      push_random(110);
      wait_drained();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
